// ===== rtl/weighted_l1_loss_reduce_unit_assert.svh =====
// Assertion macros for the weighted L1 loss reduce unit.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef WEIGHTED_L1_LOSS_REDUCE_UNIT_ASSERT_SVH
`define WEIGHTED_L1_LOSS_REDUCE_UNIT_ASSERT_SVH

// Fail when the condition holds at any edge.
`define WL1R_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

// Fail when the antecedent holds and the consequent does not, at the same edge.
`define WL1R_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Fail when the antecedent holds and the consequent does not, at the next edge.
`define WL1R_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/wl1r_pkg.sv =====
`default_nettype none

package wl1r_pkg;

  localparam int unsigned SampleWidthDef = 16;
  localparam int unsigned MaxElementsDef = 65536;

  localparam int unsigned AccWidth   = 48;
  localparam int unsigned CountWidth = 17;
  localparam int unsigned ScaleShift = 8;
  localparam int unsigned NumWidth   = AccWidth + ScaleShift;
  localparam int unsigned DivSteps   = NumWidth;
  localparam int unsigned StepWidth  = $clog2(DivSteps);
  localparam int unsigned QueueDepth = 4;

  localparam logic signed [AccWidth-1:0] AccMax = {1'b0, {(AccWidth-1){1'b1}}};
  localparam logic signed [AccWidth-1:0] AccMin = {1'b1, {(AccWidth-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_NONE       = 2'd0,
    MODE_SUM        = 2'd1,
    MODE_MEAN_WSUM  = 2'd2,
    MODE_MEAN_COUNT = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OP_PASS      = 2'd0,
    OP_DIV_WSUM  = 2'd1,
    OP_DIV_COUNT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_HOLD = 2'd2
  } back_state_e;

  typedef struct packed {
    op_e                         op;
    logic signed [AccWidth-1:0]  num;
    logic signed [AccWidth-1:0]  den;
    logic                        last;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/wl1r_front.sv =====
`default_nettype none

module wl1r_front #(
  parameter int unsigned SampleWidth = wl1r_pkg::SampleWidthDef,
  parameter int unsigned MaxElements = wl1r_pkg::MaxElementsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wl1r_pkg::mode_e               mode_i,
  input  logic signed [SampleWidth-1:0] prediction_i,
  input  logic signed [SampleWidth-1:0] label_i,
  input  logic signed [SampleWidth-1:0] weight_i,
  input  logic                          final_element_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  output logic                          push_o,
  output wl1r_pkg::job_t                job_o,
  input  logic                          full_i
);
  import wl1r_pkg::*;

  localparam int unsigned DiffW = SampleWidth + 1;
  localparam int unsigned ProdW = DiffW + SampleWidth;
  localparam int unsigned CmpW  = (ProdW > AccWidth + 1) ? ProdW : AccWidth + 1;
  localparam int unsigned CountMax = (1 << CountWidth) - 1;
  localparam logic [CountWidth-1:0] CountLimit =
    (MaxElements < CountMax) ? CountWidth'(MaxElements) : CountWidth'(CountMax);

  function automatic logic signed [AccWidth-1:0] sat_add(
    input logic signed [AccWidth-1:0] a,
    input logic signed [AccWidth-1:0] b
  );
    logic [AccWidth:0] s;
    s = {a[AccWidth-1], a} + {b[AccWidth-1], b};
    if (s[AccWidth] != s[AccWidth-1]) begin
      return s[AccWidth] ? AccMin : AccMax;
    end
    return s[AccWidth-1:0];
  endfunction

  logic [DiffW-1:0]       diff;
  logic [DiffW-1:0]       diff_mag;
  logic [SampleWidth-1:0] w_mag;
  logic [ProdW-1:0]       prod;

  logic                          s1_valid_q;
  logic [ProdW-1:0]              s1_prod_q;
  logic signed [SampleWidth-1:0] s1_w_q;
  logic                          s1_last_q;
  mode_e                         s1_mode_q;

  logic signed [AccWidth-1:0] esum_q, esum_n;
  logic signed [AccWidth-1:0] wsum_q, wsum_n;
  logic [CountWidth-1:0]      cnt_q, cnt_n;

  logic [CmpW-1:0]            prod_ext;
  logic                       prod_ovf;
  logic                       w_neg;
  logic [AccWidth-1:0]        prod_lo;
  logic signed [AccWidth-1:0] err;
  logic signed [AccWidth-1:0] w_ext;
  logic                       need_push;
  logic                       adv;

  assign diff     = {prediction_i[SampleWidth-1], prediction_i}
                  - {label_i[SampleWidth-1], label_i};
  assign diff_mag = diff[DiffW-1] ? (~diff + DiffW'(1)) : diff;
  assign w_mag    = weight_i[SampleWidth-1] ? (~weight_i + SampleWidth'(1)) : weight_i;
  assign prod     = ProdW'(diff_mag) * ProdW'(w_mag);

  assign w_neg    = s1_w_q[SampleWidth-1];
  assign prod_ext = CmpW'(s1_prod_q);
  assign prod_ovf = prod_ext > CmpW'($unsigned(AccMax));
  assign prod_lo  = AccWidth'(s1_prod_q);

  always_comb begin
    if (prod_ovf) begin
      err = w_neg ? AccMin : AccMax;
    end else begin
      err = w_neg ? (~prod_lo + AccWidth'(1)) : prod_lo;
    end
  end

  assign w_ext  = {{(AccWidth-SampleWidth){s1_w_q[SampleWidth-1]}}, s1_w_q};
  assign esum_n = sat_add(esum_q, err);
  assign wsum_n = sat_add(wsum_q, w_ext);
  assign cnt_n  = ((s1_w_q != '0) && (cnt_q < CountLimit)) ? cnt_q + CountWidth'(1) : cnt_q;

  assign need_push  = (s1_mode_q == MODE_NONE) || s1_last_q;
  assign adv        = !s1_valid_q || !need_push || !full_i;
  assign push_o     = s1_valid_q && need_push && !full_i;
  assign in_stall_o = !adv;

  always_comb begin
    job_o.last = s1_last_q;
    job_o.den  = wsum_n;
    unique case (s1_mode_q)
      MODE_NONE: begin
        job_o.op  = OP_PASS;
        job_o.num = err;
      end
      MODE_SUM: begin
        job_o.op  = OP_PASS;
        job_o.num = esum_n;
      end
      MODE_MEAN_WSUM: begin
        job_o.op  = OP_DIV_WSUM;
        job_o.num = esum_n;
      end
      MODE_MEAN_COUNT: begin
        job_o.op  = OP_DIV_COUNT;
        job_o.num = esum_n;
        job_o.den = AccWidth'(cnt_n);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      s1_prod_q <= prod;
      s1_w_q    <= weight_i;
      s1_last_q <= final_element_i;
      s1_mode_q <= mode_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esum_q <= '0;
      wsum_q <= '0;
      cnt_q  <= '0;
    end else if (s1_valid_q && adv) begin
      if (s1_last_q) begin
        esum_q <= '0;
        wsum_q <= '0;
        cnt_q  <= '0;
      end else begin
        esum_q <= esum_n;
        wsum_q <= wsum_n;
        cnt_q  <= cnt_n;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wl1r_queue.sv =====
`default_nettype none

module wl1r_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wl1r_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output wl1r_pkg::job_t job_o
);
  import wl1r_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  job_t              mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]     count_q, count_d;

  assign full_o  = count_q == (PtrW+1)'(QueueDepth);
  assign valid_o = count_q != '0;
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + (PtrW+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wl1r_back.sv =====
`default_nettype none

module wl1r_back (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  input  wl1r_pkg::job_t                          job_i,
  output logic                                    pop_o,
  output logic signed [wl1r_pkg::AccWidth-1:0]    loss_value_o,
  output logic                                    result_last_o,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i
);
  import wl1r_pkg::*;

  back_state_e state_q, state_d;

  logic [AccWidth-1:0]  rem_q;
  logic [NumWidth-1:0]  quo_q;
  logic [AccWidth-1:0]  den_q;
  logic                 neg_q;
  logic                 zero_q;
  logic                 last_q;
  logic [StepWidth-1:0] step_q;

  logic                       out_valid_q;
  logic signed [AccWidth-1:0] out_loss_q;
  logic                       out_last_q;

  logic                out_free;
  logic                load_pass;
  logic                load_div;
  logic                load_quot;
  logic                step_en;
  logic                step_done;

  logic [AccWidth-1:0] num_mag;
  logic [AccWidth-1:0] wden_mag;
  logic [AccWidth-1:0] den_load;
  logic [NumWidth-1:0] num_load;
  logic                neg_load;

  logic [AccWidth:0]   rem_shift;
  logic [AccWidth+1:0] trial;
  logic                fits;

  logic                quo_ovf;
  logic signed [AccWidth-1:0] quot_val;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign step_done = step_q == StepWidth'(DivSteps - 1);

  assign num_mag  = job_i.num[AccWidth-1] ? (~job_i.num + AccWidth'(1)) : job_i.num;
  assign wden_mag = job_i.den[AccWidth-1] ? (~job_i.den + AccWidth'(1)) : job_i.den;

  always_comb begin
    if (job_i.op == OP_DIV_WSUM) begin
      num_load = {num_mag, {ScaleShift{1'b0}}};
      den_load = wden_mag;
      neg_load = job_i.num[AccWidth-1] != job_i.den[AccWidth-1];
    end else begin
      num_load = NumWidth'(num_mag);
      den_load = job_i.den;
      neg_load = job_i.num[AccWidth-1];
    end
  end

  assign rem_shift = {rem_q, quo_q[NumWidth-1]};
  assign trial     = {1'b0, rem_shift} - {2'b00, den_q};
  assign fits      = !trial[AccWidth+1];

  assign quo_ovf = quo_q > NumWidth'($unsigned(AccMax));

  always_comb begin
    if (zero_q) begin
      quot_val = '0;
    end else if (quo_ovf) begin
      quot_val = neg_q ? AccMin : AccMax;
    end else if (neg_q) begin
      quot_val = ~AccWidth'(quo_q) + AccWidth'(1);
    end else begin
      quot_val = AccWidth'(quo_q);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (valid_i && (job_i.op != OP_PASS)) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_done) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    load_pass = 1'b0;
    load_div  = 1'b0;
    load_quot = 1'b0;
    step_en   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (valid_i) begin
          if (job_i.op == OP_PASS) begin
            if (out_free) begin
              pop_o     = 1'b1;
              load_pass = 1'b1;
            end
          end else begin
            pop_o    = 1'b1;
            load_div = 1'b1;
          end
        end
      end
      ST_DIV: begin
        step_en = 1'b1;
      end
      ST_HOLD: begin
        load_quot = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_pass || load_quot) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_div) begin
      rem_q  <= '0;
      quo_q  <= num_load;
      den_q  <= den_load;
      neg_q  <= neg_load;
      zero_q <= den_load == '0;
      last_q <= job_i.last;
      step_q <= '0;
    end else if (step_en) begin
      rem_q  <= fits ? trial[AccWidth-1:0] : rem_shift[AccWidth-1:0];
      quo_q  <= {quo_q[NumWidth-2:0], fits};
      step_q <= step_q + StepWidth'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_pass) begin
      out_loss_q <= job_i.num;
      out_last_q <= job_i.last;
    end else if (load_quot) begin
      out_loss_q <= quot_val;
      out_last_q <= last_q;
    end
  end

  assign loss_value_o  = out_loss_q;
  assign result_last_o = out_last_q;
  assign out_valid_o   = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/weighted_l1_loss_reduce_unit.sv =====
// Weighted L1 loss with streaming reduction.
// Input channel: prediction_i, label_i, weight_i, final_element_i with
// in_valid_i / in_stall_o; a request is taken when valid is high and stall low.
// Output channel: loss_value_o, result_last_o with out_valid_o / out_stall_i.
// reduction_mode is written through cfg_we_i / cfg_wdata_i; the user must
// write it only while idle, as the block does not enforce this. Mode none
// gives one result per element; the reducing modes give one result on the
// final element. Accumulators clear after every final element. Per-element
// results and the plain sum pass through the s1 register, the job queue and the
// output register; mean modes add the back end's 56-step restoring divider.
// Throughput: one element per cycle unless a job push meets a full queue; a
// division holds the back end; the front runs on until the 4-entry queue fills.
// A stalled result holds in the output register; the queue then fills and
// in_stall_o rises. Reset clears the accumulators, empties the queue and sets
// the mode to sum; no clearing pass is needed.
`default_nettype none
`include "weighted_l1_loss_reduce_unit_assert.svh"

module weighted_l1_loss_reduce_unit #(
  parameter int unsigned SampleWidth = wl1r_pkg::SampleWidthDef,
  parameter int unsigned MaxElements = wl1r_pkg::MaxElementsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [1:0]                           cfg_wdata_i,
  input  logic signed [SampleWidth-1:0]        prediction_i,
  input  logic signed [SampleWidth-1:0]        label_i,
  input  logic signed [SampleWidth-1:0]        weight_i,
  input  logic                                 final_element_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  output logic signed [wl1r_pkg::AccWidth-1:0] loss_value_o,
  output logic                                 result_last_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i
);
  import wl1r_pkg::*;

  mode_e mode_q;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  job_t  push_job;
  job_t  head_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SUM;
    end else if (cfg_we_i) begin
      mode_q <= mode_e'(cfg_wdata_i);
    end
  end

  wl1r_front #(
    .SampleWidth (SampleWidth),
    .MaxElements (MaxElements)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mode_i          (mode_q),
    .prediction_i    (prediction_i),
    .label_i         (label_i),
    .weight_i        (weight_i),
    .final_element_i (final_element_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .push_o          (q_push),
    .job_o           (push_job),
    .full_i          (q_full)
  );

  wl1r_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  wl1r_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .job_i         (head_job),
    .pop_o         (q_pop),
    .loss_value_o  (loss_value_o),
    .result_last_o (result_last_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i)
  );

  `WL1R_ASSERT_NEVER(a_queue_overflow, q_push && q_full, "job pushed into full queue")
  `WL1R_ASSERT_NEVER(a_queue_underflow, q_pop && !q_valid, "job popped from empty queue")
  `WL1R_ASSERT_IMPLIES(a_stall_cause, in_stall_o, q_full, "input stalled with queue space")
  `WL1R_ASSERT_NEXT(a_push_lands, q_push && !q_pop, q_valid, "pushed job not visible")

endmodule

`default_nettype wire

// ===== test/weighted_l1_loss_reduce_unit_tb.sv =====
`timescale 1ns / 1ps

module weighted_l1_loss_reduce_unit_tb;
  import wl1r_pkg::*;

  localparam int unsigned Sw = SampleWidthDef;
  localparam longint LossHi = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint LossLo = -LossHi - 1;
  localparam int CountCap = (MaxElementsDef < 131071) ? MaxElementsDef : 131071;
  localparam int Settle = 70;
  localparam int HoldCycles = 400;
  localparam int SatPairs = 257;

  typedef enum logic [1:0] {
    REQ_ELEM  = 2'd0,
    REQ_MODE  = 2'd1,
    REQ_DRAIN = 2'd2,
    REQ_HOLD  = 2'd3
  } req_kind_e;

  typedef struct {
    req_kind_e             kind;
    logic signed [Sw-1:0]  pred;
    logic signed [Sw-1:0]  lbl;
    logic signed [Sw-1:0]  wgt;
    logic                  fin;
    mode_e                 mode;
    int unsigned           gap;
  } req_t;

  typedef struct {
    logic signed [AccWidth-1:0] value;
    logic                       last;
  } loss_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [1:0]                  cfg_wdata_i = '0;
  logic signed [Sw-1:0]        prediction_i = '0;
  logic signed [Sw-1:0]        label_i = '0;
  logic signed [Sw-1:0]        weight_i = '0;
  logic                        final_element_i = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic signed [AccWidth-1:0]  loss_value_o;
  logic                        result_last_o;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;

  req_t   req_q[$];
  loss_t  loss_q[$];
  req_t   cur_req;

  mode_e  mode_q = MODE_SUM;
  longint err_acc = 0;
  longint wsum_acc = 0;
  int     nz_cnt = 0;

  int     mismatches = 0;
  int     hold_seq = 0;
  int     hold_seen;
  int     hold_left;
  int     run_left;
  int     gap_left;
  int     quiet;

  weighted_l1_loss_reduce_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .prediction_i    (prediction_i),
    .label_i         (label_i),
    .weight_i        (weight_i),
    .final_element_i (final_element_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .loss_value_o    (loss_value_o),
    .result_last_o   (result_last_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i)
  );

  function automatic longint sat48(longint x);
    if (x > LossHi) return LossHi;
    if (x < LossLo) return LossLo;
    return x;
  endfunction

  function automatic longint unsigned mag(longint x);
    return (x < 0) ? longint'(-x) : x;
  endfunction

  function automatic longint signed_from_mag(longint unsigned m, bit neg);
    if (neg) begin
      if (m >= longint'(LossHi) + 1) return LossLo;
      return -longint'(m);
    end
    if (m > LossHi) return LossHi;
    return longint'(m);
  endfunction

  function automatic longint div_toward_zero(longint num, longint den);
    if (den == 0) return 0;
    return signed_from_mag(mag(num) / mag(den), (num < 0) != (den < 0));
  endfunction

  task automatic account_element(input req_t e);
    longint p;
    longint l;
    longint w;
    longint err;
    longint unsigned prod;
    loss_t res;
    bit emit;
    p = e.pred;
    l = e.lbl;
    w = e.wgt;
    prod = mag(p - l) * mag(w);
    err = signed_from_mag(prod, (w < 0) && (prod != 0));
    err_acc = sat48(err_acc + err);
    wsum_acc = sat48(wsum_acc + w);
    if (w != 0 && nz_cnt < CountCap) nz_cnt++;
    emit = 1'b1;
    res.last = e.fin;
    if (mode_q == MODE_NONE) begin
      res.value = err[AccWidth-1:0];
    end else if (e.fin) begin
      case (mode_q)
        MODE_SUM:       res.value = err_acc[AccWidth-1:0];
        MODE_MEAN_WSUM: res.value = AccWidth'(div_toward_zero(err_acc * 256, wsum_acc));
        default:        res.value = AccWidth'(div_toward_zero(err_acc, longint'(nz_cnt)));
      endcase
    end else begin
      emit = 1'b0;
    end
    if (emit) loss_q.push_back(res);
    if (e.fin) begin
      err_acc = 0;
      wsum_acc = 0;
      nz_cnt = 0;
    end
  endtask

  function automatic logic signed [Sw-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      3: return 16'($urandom_range(0, 511)) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void push_elem(logic signed [Sw-1:0] p, logic signed [Sw-1:0] l,
                                    logic signed [Sw-1:0] w, logic fin, int unsigned gap);
    req_t r;
    r.kind = REQ_ELEM;
    r.pred = p;
    r.lbl  = l;
    r.wgt  = w;
    r.fin  = fin;
    r.mode = MODE_SUM;
    r.gap  = gap;
    req_q.push_back(r);
  endfunction

  function automatic void push_mark(req_kind_e kind, mode_e m);
    req_t r;
    r.kind = kind;
    r.pred = '0;
    r.lbl  = '0;
    r.wgt  = '0;
    r.fin  = 1'b0;
    r.mode = m;
    r.gap  = 0;
    req_q.push_back(r);
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    logic next_valid;
    logic next_we;
    req_t head;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cfg_we_i <= 1'b0;
      prediction_i <= '0;
      label_i <= '0;
      weight_i <= '0;
      final_element_i <= 1'b0;
      cur_req.pred = '0;
      cur_req.lbl = '0;
      cur_req.wgt = '0;
      cur_req.fin = 1'b0;
      gap_left = 0;
      quiet = 0;
    end else begin
      next_valid = in_valid_i;
      next_we = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        account_element(cur_req);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (req_q.size() != 0) begin
          head = req_q[0];
          case (head.kind)
            REQ_ELEM: begin
              cur_req = head;
              next_valid = 1'b1;
              gap_left = head.gap;
              void'(req_q.pop_front());
            end
            REQ_HOLD: begin
              hold_seq <= hold_seq + 1;
              void'(req_q.pop_front());
            end
            default: begin
              if (loss_q.size() != 0) begin
                quiet = 0;
              end else if (quiet < Settle) begin
                quiet++;
              end else begin
                quiet = 0;
                if (head.kind == REQ_MODE) begin
                  next_we = 1'b1;
                  cfg_wdata_i <= head.mode;
                  mode_q = head.mode;
                end
                void'(req_q.pop_front());
              end
            end
          endcase
        end
      end
      in_valid_i <= next_valid;
      cfg_we_i <= next_we;
      prediction_i <= cur_req.pred;
      label_i <= cur_req.lbl;
      weight_i <= cur_req.wgt;
      final_element_i <= cur_req.fin;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : drive_stall
    logic next_stall;
    int r;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_seen = 0;
      hold_left = 0;
      run_left = 0;
    end else begin
      next_stall = out_stall_i;
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = HoldCycles;
        next_stall = 1'b1;
      end else if (hold_left != 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else if (run_left != 0) begin
        run_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          next_stall = 1'b0;
          run_left = $urandom_range(0, 3);
        end else if (r < 60) begin
          next_stall = 1'b0;
          run_left = $urandom_range(20, 80);
        end else if (r < 95) begin
          next_stall = 1'b1;
          run_left = $urandom_range(0, 3);
        end else begin
          next_stall = 1'b1;
          run_left = $urandom_range(20, 60);
        end
      end
      out_stall_i <= next_stall;
    end
  end

  always @(posedge clk_i) begin : check_losses
    loss_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (loss_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected loss %0d last %0b", loss_value_o, result_last_o);
      end else begin
        want = loss_q.pop_front();
        if (want.value !== loss_value_o || want.last !== result_last_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("loss mismatch: expected %0d last %0b, got %0d last %0b",
                     want.value, want.last, loss_value_o, result_last_o);
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int n;
    int len;
    bit held;
    bit calm;
    bit scalar;
    logic signed [Sw-1:0] w0;

    // sum mode straight out of reset
    push_elem(16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1, 0);
    push_elem(16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0, 0);
    push_elem('0, '0, '0, 1'b0, 0);
    push_elem(16'sh0100, 16'sh0080, -16'sd1, 1'b1, 0);
    push_mark(REQ_MODE, MODE_NONE);
    push_elem(16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0, 0);
    push_elem(16'sd1, -16'sd1, 16'sd1, 1'b0, 0);
    push_elem(16'sd5, 16'sd5, 16'sh7FFF, 1'b1, 0);
    push_mark(REQ_MODE, MODE_MEAN_WSUM);
    push_elem(16'sh0200, '0, 16'sh0100, 1'b0, 0);
    push_elem('0, 16'sh0300, 16'sh0080, 1'b1, 0);
    push_elem(16'sh0100, '0, 16'sh0100, 1'b0, 0);
    push_elem(16'sh0100, '0, -16'sh0100, 1'b1, 0);
    push_elem(16'sh0100, '0, -16'sh0180, 1'b1, 0);
    push_mark(REQ_MODE, MODE_MEAN_COUNT);
    push_elem(16'sh7FFF, '0, '0, 1'b1, 0);
    push_elem(16'sh0100, '0, 16'sh0100, 1'b0, 0);
    push_elem('0, 16'sh0100, '0, 1'b0, 0);
    push_elem(16'sh0300, '0, -16'sh0040, 1'b1, 0);
    // switch mode part way through an array
    push_mark(REQ_MODE, MODE_SUM);
    push_elem(16'sh0100, '0, 16'sh0100, 1'b0, 0);
    push_elem(-16'sh0100, 16'sh0040, 16'sh0200, 1'b0, 0);
    push_mark(REQ_MODE, MODE_NONE);
    push_elem(16'sh0200, '0, 16'sh0100, 1'b0, 0);
    push_mark(REQ_MODE, MODE_SUM);
    push_elem(16'sh0010, 16'sh0020, -16'sh0300, 1'b1, 0);

    n = 0;
    held = 1'b0;
    while (n < 200) begin
      if (!held && n >= 80) begin
        held = 1'b1;
        push_mark(REQ_MODE, MODE_NONE);
        push_mark(REQ_HOLD, MODE_NONE);
        for (int i = 0; i < 48; i++)
          push_elem(pick_sample(), pick_sample(), pick_sample(), i == 47, 0);
        n += 48;
      end
      if ($urandom_range(0, 2) == 0) push_mark(REQ_MODE, mode_e'($urandom_range(0, 3)));
      if ($urandom_range(0, 9) == 0) push_mark(REQ_DRAIN, MODE_SUM);
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      calm = ($urandom_range(0, 3) == 0);
      scalar = ($urandom_range(0, 1) == 0);
      w0 = pick_sample();
      for (int i = 0; i < len; i++)
        push_elem(pick_sample(), pick_sample(), scalar ? w0 : pick_sample(), i == len - 1,
                  calm ? 0 : pick_gap());
      n += len;
    end

    // large error sum over a weight sum of one: quotient saturates
    push_mark(REQ_MODE, MODE_MEAN_WSUM);
    for (int i = 0; i < SatPairs; i++) begin
      push_elem(16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0, 0);
      push_elem('0, '0, 16'sh8001, 1'b0, 0);
    end
    push_elem('0, '0, 16'sd1, 1'b1, 0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || in_valid_i || loss_q.size() != 0) @(negedge clk_i);
    repeat (Settle) @(posedge clk_i);

    if (mismatches == 0 && loss_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/wl1r_pkg.sv
rtl/wl1r_front.sv
rtl/wl1r_queue.sv
rtl/wl1r_back.sv
rtl/weighted_l1_loss_reduce_unit.sv
test/weighted_l1_loss_reduce_unit_tb.sv
